// ----- hdl/gds_pkg.sv -----
// ---------------------------------------------------------------------------
// gds_pkg
// Shared types, calendar constants and month-length helpers for the
// Gregorian date shifter.
// ---------------------------------------------------------------------------
package gds_pkg;

  // Working year: signed so one step below year zero is visible.
  typedef logic signed [15:0] year_t;
  // Year modulo the 400-year Gregorian cycle.
  typedef logic [8:0] ymod_t;

  // Configuration register indexes
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  localparam logic [13:0] MIN_YEAR_RST = 14'd1;
  localparam logic [13:0] MAX_YEAR_RST = 14'd9999;

  localparam ymod_t YEAR_CYCLE   = 9'd400;
  localparam ymod_t CENTURY      = 9'd100;
  localparam ymod_t CENTURY_2    = 9'd200;
  localparam ymod_t CENTURY_3    = 9'd300;
  localparam ymod_t YEAR_CYC_TOP = 9'd399;

  localparam logic [4:0] FEB_DAYS      = 5'd28;
  localparam logic [4:0] FEB_DAYS_LEAP = 5'd29;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Steps of the restoring year-mod-400 reduction (400 << 5 .. 400 << 0)
  localparam logic [2:0] REDUCE_TOP = 3'd5;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // 4/100/400 leap rule on the year residue; negative years are never leap
  function automatic logic is_leap(input ymod_t ymod, input logic neg);
    logic century;
    century = (ymod == '0) || (ymod == CENTURY) || (ymod == CENTURY_2) ||
              (ymod == CENTURY_3);
    return !neg && (ymod[1:0] == 2'b00) && !(century && ymod != '0);
  endfunction

  // Days in a month (1..12); anything else reads as 31
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month == MONTH_FEB) begin
      len = leap ? FEB_DAYS_LEAP : FEB_DAYS;
    end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
      len = MONTH_LEN[month - MONTH_JAN];
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ----- hdl/gregorian_date_shifter_unit.sv -----
// ---------------------------------------------------------------------------
// gregorian_date_shifter_unit
// Shifts a Gregorian date by a signed number of days, one day per cycle,
// and flags a year that leaves the configured range.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------
//  in       | in        | in_valid / in_ready   | start_day, start_month, start_year,
//           |           |                       | day_shift
//  out      | out       | out_valid / out_ready | end_day, end_month, end_year,
//           |           |                       | out_of_range
//  cfg      | in        | cfg_write             | cfg_index, cfg_data
//
//  An accepted request runs through year-mod-400 reduction, a day-correction
//  step, one day per step through the shared one-day step unit, a final check
//  and a load into the output register.
//  An out-of-range year ends the stepping early.
//  Reset (rst, synchronous) returns to idle, empties the output register and
//  restores min_year = 1, max_year = 9999.
//  The result waits in the output register while in_ready is high again; a
//  finished request stalls in its last state until that register is free.
// ---------------------------------------------------------------------------
module gregorian_date_shifter_unit
  import gds_pkg::*;
#(
  parameter int SHIFT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [13:0]                   cfg_data,
  // request
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [4:0]                    start_day,
  input  logic [3:0]                    start_month,
  input  logic [13:0]                   start_year,
  input  logic signed [SHIFT_WIDTH-1:0] day_shift,
  // result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    end_day,
  output logic [3:0]                    end_month,
  output logic [13:0]                   end_year,
  output logic                          out_of_range
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CLAMP,
    S_STEP,
    S_DONE
  } state_t;

  state_t                 state;
  logic [13:0]            min_year;
  logic [13:0]            max_year;

  // Working date and step count
  logic [4:0]             work_day;
  logic [3:0]             work_month;
  year_t                  work_year;
  ymod_t                  ymod;
  logic [13:0]            rem;
  logic [2:0]             red_cnt;
  logic [SHIFT_WIDTH-1:0] steps_left;
  logic                   backward;
  logic                   err;

  logic [SHIFT_WIDTH-1:0] shift_raw;
  logic [SHIFT_WIDTH-1:0] shift_mag;
  logic [3:0]             month_fix;
  logic [14:0]            red_diff;
  logic [4:0]             clamp_len;

  logic [4:0]             step_day;
  logic [3:0]             step_month;
  year_t                  step_year;
  ymod_t                  step_ymod;
  logic                   step_err;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RST;
      max_year <= MAX_YEAR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_YEAR: min_year <= cfg_data;
        CFG_MAX_YEAR: max_year <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Request decode: shift magnitude and month correction
  assign shift_raw = day_shift;
  assign shift_mag = shift_raw[SHIFT_WIDTH-1] ? (~shift_raw + 1'b1) : shift_raw;
  assign month_fix = (start_month == 4'd0) ? MONTH_JAN :
                     (start_month > MONTH_DEC) ? MONTH_DEC : start_month;

  // Restoring reduction of the year modulo 400
  assign red_diff = {1'b0, rem} - {1'b0, 14'({5'd0, YEAR_CYCLE} << red_cnt)};

  // Start-day correction against the month length
  assign clamp_len = days_in(work_month, is_leap(rem[8:0], 1'b0));

  // Shared one-day step unit
  gds_day_step u_step (
    .day        (work_day),
    .month      (work_month),
    .year       (work_year),
    .ymod       (ymod),
    .backward   (backward),
    .day_next   (step_day),
    .month_next (step_month),
    .year_next  (step_year),
    .ymod_next  (step_ymod)
  );

  // Range check in the direction of stepping
  assign step_err = backward ? (step_year < $signed({2'b00, min_year}))
                             : (step_year > $signed({2'b00, max_year}));

  assign in_ready = (state == S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a result taken while the next one loads is handled in S_DONE
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            work_day   <= (start_day == 5'd0) ? 5'd1 : start_day;
            work_month <= month_fix;
            work_year  <= $signed({2'b00, start_year});
            rem        <= start_year;
            red_cnt    <= REDUCE_TOP;
            steps_left <= shift_mag;
            backward   <= shift_raw[SHIFT_WIDTH-1];
            err        <= 1'b0;
            state      <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (!red_diff[14]) begin
            rem <= red_diff[13:0];
          end
          red_cnt <= red_cnt - 3'd1;
          if (red_cnt == 3'd0) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          ymod <= rem[8:0];
          if (work_day > clamp_len) begin
            work_day <= clamp_len;
          end
          state <= S_STEP;
        end
        S_STEP: begin
          if (steps_left == '0) begin
            state <= S_DONE;
          end else begin
            work_day   <= step_day;
            work_month <= step_month;
            work_year  <= step_year;
            ymod       <= step_ymod;
            steps_left <= steps_left - 1'b1;
            if (step_err) begin
              err   <= 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_of_range <= err;
            end_day      <= err ? 5'd0  : work_day;
            end_month    <= err ? 4'd0  : work_month;
            end_year     <= err ? 14'd0 : work_year[13:0];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An error result carries an all-zero date
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> end_day == 5'd0 && end_month == 4'd0 && end_year == 14'd0)
    else $error("out_of_range result with nonzero date");

  // A good result is a real calendar date
  a_good_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |->
      end_day != 5'd0 && end_month != 4'd0 && end_month <= MONTH_DEC)
    else $error("result date out of calendar range");

  // Year residue stays inside the 400-year cycle while stepping
  a_ymod_range: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> ymod < YEAR_CYCLE)
    else $error("year residue out of range");

  // A taken request closes the input until the work is done
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Day never exceeds its month length while stepping
  a_day_len: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP && !work_year[15] |->
      work_day != 5'd0 && work_day <= days_in(work_month, is_leap(ymod, 1'b0)))
    else $error("working day out of month");

endmodule

// ----- hdl/gds_day_step.sv -----
// ---------------------------------------------------------------------------
// gds_day_step
// One-day step unit: moves a date forward or backward by a single day,
// carrying into month and year and tracking the year modulo 400.
// ---------------------------------------------------------------------------
module gds_day_step
  import gds_pkg::*;
(
  input  logic [4:0] day,
  input  logic [3:0] month,
  input  year_t      year,
  input  ymod_t      ymod,
  input  logic       backward,
  output logic [4:0] day_next,
  output logic [3:0] month_next,
  output year_t      year_next,
  output ymod_t      ymod_next
);

  logic       leap_cur;
  logic       leap_prev;
  logic [3:0] prev_month;
  year_t      prev_year;
  ymod_t      prev_ymod;
  ymod_t      succ_ymod;

  // Neighbor year values for a year carry
  assign prev_ymod  = (ymod == '0) ? YEAR_CYC_TOP : ymod - 9'd1;
  assign succ_ymod  = (ymod == YEAR_CYC_TOP) ? '0 : ymod + 9'd1;
  assign prev_year  = year - 16'sd1;
  assign prev_month = (month == MONTH_JAN) ? MONTH_DEC : month - 4'd1;
  assign leap_cur   = is_leap(ymod, year[15]);
  assign leap_prev  = (month == MONTH_JAN) ? is_leap(prev_ymod, prev_year[15]) : leap_cur;

  // Single-day move
  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    ymod_next  = ymod;
    if (backward) begin
      if (day <= 5'd1) begin
        month_next = prev_month;
        day_next   = days_in(prev_month, leap_prev);
        if (month == MONTH_JAN) begin
          year_next = prev_year;
          ymod_next = prev_ymod;
        end
      end else begin
        day_next = day - 5'd1;
      end
    end else begin
      if (day >= days_in(month, leap_cur)) begin
        day_next = 5'd1;
        if (month == MONTH_DEC) begin
          month_next = MONTH_JAN;
          year_next  = year + 16'sd1;
          ymod_next  = succ_ymod;
        end else begin
          month_next = month + 4'd1;
        end
      end else begin
        day_next = day + 5'd1;
      end
    end
  end

endmodule
